/* rtl/sst_pkg.sv */
// shared types and codes for the sorted set toggle block
`default_nettype none

package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 3;
    localparam int CNT_W   = 4;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REJECT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE,
        ST_PLACE,
        ST_DONE
    } sst_state_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } sst_result_t;

endpackage

`default_nettype wire

/* rtl/sorted_set_toggle_top.sv */
// top level: sequencer, entry memory and result output register
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_ready, value            | in
//  result  | out_valid, out_ready, action,        | out
//          | position, count                      |
//
// a transaction scans the entries in order (scan stops at the first one not below
// value), then shifts entries one per cycle through the memory port and, on
// insert, writes the new value in place; in_ready is low meanwhile.
// reset clears the entry count and control; entry contents are not cleared.
// a stalled result holds in the output register; the sequencer waits for it.
`default_nettype none

module sorted_set_toggle_top #(
    parameter int CAPACITY = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sst_pkg::VALUE_W-1:0] value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [sst_pkg::ACT_W-1:0]   action,
    output logic      [sst_pkg::POS_W-1:0]   position,
    output logic      [sst_pkg::CNT_W-1:0]   count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                        done;
    sst_pkg::sst_result_t        result;
    logic                        out_free;
    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [sst_pkg::VALUE_W-1:0] mem_wdata;
    logic [IW-1:0]               mem_raddr;
    logic [sst_pkg::VALUE_W-1:0] mem_rdata;

    logic                 out_valid_reg, out_valid_next;
    sst_pkg::sst_result_t out_data_reg, out_data_next;

    sst_seq #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .done      (done),
        .result    (result),
        .out_free  (out_free),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sst_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign action    = out_data_reg.action;
    assign position  = out_data_reg.position;
    assign count     = out_data_reg.count;

endmodule

`default_nettype wire

/* rtl/sst_mem.sv */
// entry storage: one write port, one read port with registered read data
`default_nettype none

module sst_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [sst_pkg::VALUE_W-1:0] wdata,
    input  wire logic [AW-1:0]               raddr,
    output logic      [sst_pkg::VALUE_W-1:0] rdata
);

    logic [sst_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [sst_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/sst_seq.sv */
// sequencer: scans for the sorted position, then shifts entries one per cycle
`default_nettype none

module sst_seq #(
    parameter int CAPACITY = 8,
    parameter int IW       = 3,
    parameter int CW       = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sst_pkg::VALUE_W-1:0] value,
    output logic                             done,
    output sst_pkg::sst_result_t             result,
    input  wire logic                        out_free,
    output logic                             mem_we,
    output logic      [IW-1:0]               mem_waddr,
    output logic      [sst_pkg::VALUE_W-1:0] mem_wdata,
    output logic      [IW-1:0]               mem_raddr,
    input  wire logic [sst_pkg::VALUE_W-1:0] mem_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    sst_pkg::sst_state_t            state_reg, state_next;
    logic [sst_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic [CW-1:0]                  held_reg, held_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  dst_reg, dst_next;
    logic                           found_reg, found_next;
    logic [sst_pkg::ACT_W-1:0]      action_reg, action_next;

    logic          accept;
    logic          less;
    logic          last_scan;
    logic          del_more;
    logic          ins_more;
    logic [CW-1:0] new_held;

    assign accept    = in_valid && in_ready;
    // shared compare unit: one stored entry against the item per cycle
    assign less      = $signed(mem_rdata) < $signed(value_reg);
    assign last_scan = (pos_reg + ONE_C) == held_reg;
    assign del_more  = (dst_reg + TWO_C) < held_reg;
    assign ins_more  = (dst_reg - ONE_C) > pos_reg;

    always_comb
    begin
        case (action_reg)
            sst_pkg::ACT_INSERT: new_held = held_reg + ONE_C;
            sst_pkg::ACT_DELETE: new_held = held_reg - ONE_C;
            default:             new_held = held_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (held_reg == '0) ? sst_pkg::ST_DECIDE : sst_pkg::ST_SCAN;
                end
            end
            sst_pkg::ST_SCAN:
            begin
                if (!less || last_scan)
                begin
                    state_next = sst_pkg::ST_DECIDE;
                end
            end
            sst_pkg::ST_DECIDE:
            begin
                if (found_reg)
                begin
                    state_next = ((pos_reg + ONE_C) < held_reg) ? sst_pkg::ST_MOVE
                                                                : sst_pkg::ST_DONE;
                end
                else if (held_reg == CAP_C)
                begin
                    state_next = sst_pkg::ST_DONE;
                end
                else
                begin
                    state_next = (held_reg > pos_reg) ? sst_pkg::ST_MOVE : sst_pkg::ST_PLACE;
                end
            end
            sst_pkg::ST_MOVE:
            begin
                if (action_reg == sst_pkg::ACT_DELETE)
                begin
                    if (!del_more)
                    begin
                        state_next = sst_pkg::ST_DONE;
                    end
                end
                else if (!ins_more)
                begin
                    state_next = sst_pkg::ST_PLACE;
                end
            end
            sst_pkg::ST_PLACE:
            begin
                state_next = sst_pkg::ST_DONE;
            end
            sst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        value_next  = value_reg;
        held_next   = held_reg;
        pos_next    = pos_reg;
        dst_next    = dst_reg;
        found_next  = found_reg;
        action_next = action_reg;
        in_ready    = 1'b0;
        done        = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = mem_rdata;
        mem_raddr   = '0;
        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    value_next = value;
                    pos_next   = '0;
                    found_next = 1'b0;
                end
            end
            sst_pkg::ST_SCAN:
            begin
                if (less)
                begin
                    pos_next = pos_reg + ONE_C;
                    if (!last_scan)
                    begin
                        mem_raddr = IW'(pos_reg + ONE_C);
                    end
                end
                else
                begin
                    found_next = (mem_rdata == value_reg);
                end
            end
            sst_pkg::ST_DECIDE:
            begin
                if (found_reg)
                begin
                    action_next = sst_pkg::ACT_DELETE;
                    dst_next    = pos_reg;
                    if ((pos_reg + ONE_C) < held_reg)
                    begin
                        mem_raddr = IW'(pos_reg + ONE_C);
                    end
                end
                else if (held_reg == CAP_C)
                begin
                    action_next = sst_pkg::ACT_REJECT;
                    pos_next    = '0;
                end
                else
                begin
                    action_next = sst_pkg::ACT_INSERT;
                    dst_next    = held_reg;
                    if (held_reg > pos_reg)
                    begin
                        mem_raddr = IW'(held_reg - ONE_C);
                    end
                end
            end
            sst_pkg::ST_MOVE:
            begin
                // write the entry read last cycle, read the next source
                mem_we    = 1'b1;
                mem_waddr = IW'(dst_reg);
                mem_wdata = mem_rdata;
                if (action_reg == sst_pkg::ACT_DELETE)
                begin
                    dst_next = dst_reg + ONE_C;
                    if (del_more)
                    begin
                        mem_raddr = IW'(dst_reg + TWO_C);
                    end
                end
                else
                begin
                    dst_next = dst_reg - ONE_C;
                    if (ins_more)
                    begin
                        mem_raddr = IW'(dst_reg - TWO_C);
                    end
                end
            end
            sst_pkg::ST_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(pos_reg);
                mem_wdata = value_reg;
            end
            sst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    done      = 1'b1;
                    held_next = new_held;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.action   = action_reg;
    assign result.position = sst_pkg::POS_W'(pos_reg);
    assign result.count    = sst_pkg::CNT_W'(new_held);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        dst_reg    <= dst_next;
        found_reg  <= found_next;
        action_reg <= action_next;
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CAP_C)
        else $error("entry count above capacity");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sst_pkg::ST_DONE && action_reg == sst_pkg::ACT_REJECT)
        |-> (held_reg == CAP_C && pos_reg == '0))
        else $error("reject while set not full");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("ready right after an accepted transaction");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_free && state_reg == sst_pkg::ST_DONE))
        else $error("result issued while output register busy");

endmodule

`default_nettype wire

/* verif/tb_sorted_set_toggle_top.sv */
// testbench for sorted_set_toggle_top: toggles values into the set and checks each result
`default_nettype none

module tb_sorted_set_toggle_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_SLOTS     = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int RANDOM_ITEMS  = 440;
    localparam int POOL_SIZE     = 10;
    localparam int DRAIN_CYCLES  = 40;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [sst_pkg::VALUE_W-1:0]   value;
    logic                          out_valid;
    logic                          out_ready;
    logic [sst_pkg::ACT_W-1:0]     action;
    logic [sst_pkg::POS_W-1:0]     position;
    logic [sst_pkg::CNT_W-1:0]     count;

    int unsigned                   accepted_items;
    int unsigned                   cycle_count;
    bit                            calm;
    bit                            held_off;
    logic [sst_pkg::VALUE_W-1:0]   pool [POOL_SIZE];

    class set_scoreboard;
        logic signed [sst_pkg::VALUE_W-1:0] members [SET_SLOTS];
        int unsigned                        held;
        sst_pkg::sst_result_t               pending [$];
        int unsigned                        failures;

        task report(string what);
            failures++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // toggle membership of one value and return the result it causes
        function sst_pkg::sst_result_t toggle_value(logic signed [sst_pkg::VALUE_W-1:0] v);
            sst_pkg::sst_result_t r;
            int unsigned spot;
            int unsigned i;
            spot = 0;
            while (spot < held && members[spot] < v)
                spot++;
            if (spot < held && members[spot] == v) begin
                for (i = spot; i + 1 < held; i++)
                    members[i] = members[i + 1];
                held--;
                r.action = sst_pkg::ACT_DELETE;
            end
            else if (held >= SET_SLOTS) begin
                spot = 0;
                r.action = sst_pkg::ACT_REJECT;
            end
            else begin
                for (i = held; i > spot; i--)
                    members[i] = members[i - 1];
                members[spot] = v;
                held++;
                r.action = sst_pkg::ACT_INSERT;
            end
            r.position = sst_pkg::POS_W'(spot);
            r.count    = sst_pkg::CNT_W'(held);
            return r;
        endfunction

        function void note_value(logic [sst_pkg::VALUE_W-1:0] v);
            pending.push_back(toggle_value(v));
        endfunction

        task check_result(sst_pkg::sst_result_t got);
            sst_pkg::sst_result_t want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: action %0d position %0d count %0d",
                                 got.action, got.position, got.count));
                return;
            end
            want = pending.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.position !== want.position)
                report($sformatf("position %0d, want %0d", got.position, want.position));
            if (got.count !== want.count)
                report($sformatf("count %0d, want %0d", got.count, want.count));
        endtask
    endclass

    set_scoreboard sb;

    sorted_set_toggle_top #(
        .CAPACITY (SET_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .action    (action),
        .position  (position),
        .count     (count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_value(input logic [sst_pkg::VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_value(v);
        accepted_items++;
        @(negedge clk);
    endtask

    task automatic refresh_pool();
        int r;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            r = $urandom_range(5);
            case (r)
                0: pool[k] = 32'h8000_0000;
                1: pool[k] = 32'h7fff_ffff;
                2, 3: pool[k] = sst_pkg::VALUE_W'($urandom_range(20)) - 32'd10;
                default: pool[k] = $urandom;
            endcase
        end
    endtask

    // result channel: random stalls plus one long hold-off to back the block up
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && accepted_items >= HOLD_AT_ITEM)
            begin
                held_off = 1'b1;
                stall = HOLD_CYCLES;
            end
            else if ($urandom_range(3) == 0)
                stall = pick_gap();
            else
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        sst_pkg::sst_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.action   = action;
                got.position = position;
                got.count    = count;
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        logic [sst_pkg::VALUE_W-1:0] directed [$];
        sb = new;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        calm           = 1'b0;
        held_off       = 1'b0;
        accepted_items = 0;
        cycle_count    = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill to capacity with the extremes, reject while full, delete while full,
        // then delete first, last and middle entries and append at the top
        directed = '{32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'hffff_ffff, 32'd1,
                     32'd5, 32'hffff_fffb, 32'd100, 32'd42, 32'h8000_0000,
                     32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 32'hffff_fffb, 32'd100,
                     32'hffff_ffff, 32'd1, 32'd5, 32'h7fff_ffff, 32'h5555_aaaa,
                     32'haaaa_5555};
        foreach (directed[k])
            send_value(directed[k]);

        refresh_pool();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 59)
                refresh_pool();
            if (n % 40 == 0)
                calm = ($urandom_range(3) == 0);
            // mostly values from a small pool so the set fills, empties and rejects
            if ($urandom_range(9) < 8)
                send_value(pool[$urandom_range(POOL_SIZE - 1)]);
            else
                send_value($urandom);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
